// ===== hw/rtl/c8ic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared constants, step codes, opcode fields and the font table of the
// CHIP-8 interpreter core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;

    localparam int MEM_AW   = $clog2(MEM_BYTES);
    localparam int STK_AW   = $clog2(STACK_DEPTH);
    localparam int LVL_W    = $clog2(STACK_DEPTH + 1);
    localparam int ROW_AW   = $clog2(SCREEN_H);
    localparam int COL_AW   = $clog2(SCREEN_W);
    localparam int CNT_W    = MEM_AW;
    localparam int FONT_LEN = 80;

    localparam logic [MEM_AW-1:0] PC_RESET  = 12'h200;
    localparam logic [MEM_AW-1:0] FONT_BASE = 12'h050;

    // item kinds
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_EXEC     = 2'd1;
    localparam logic [1:0] OP_READ_ROW = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_KEY_WAIT  = 2'd3;

    // sequencer steps
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MWR   = 5'd2;
    localparam logic [4:0] S_ROW0  = 5'd3;
    localparam logic [4:0] S_ROW1  = 5'd4;
    localparam logic [4:0] S_F0    = 5'd5;
    localparam logic [4:0] S_F1    = 5'd6;
    localparam logic [4:0] S_F2    = 5'd7;
    localparam logic [4:0] S_RX    = 5'd8;
    localparam logic [4:0] S_RY    = 5'd9;
    localparam logic [4:0] S_EXEC  = 5'd10;
    localparam logic [4:0] S_VF    = 5'd11;
    localparam logic [4:0] S_DRAW0 = 5'd12;
    localparam logic [4:0] S_DRAW1 = 5'd13;
    localparam logic [4:0] S_BCD   = 5'd14;
    localparam logic [4:0] S_ST    = 5'd15;
    localparam logic [4:0] S_LD    = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    // instruction groups (top nibble)
    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_JP    = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SE    = 4'h3;
    localparam logic [3:0] GRP_SNE   = 4'h4;
    localparam logic [3:0] GRP_SEXY  = 4'h5;
    localparam logic [3:0] GRP_LD    = 4'h6;
    localparam logic [3:0] GRP_ADD   = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNEXY = 4'h9;
    localparam logic [3:0] GRP_LDI   = 4'hA;
    localparam logic [3:0] GRP_JPV0  = 4'hB;
    localparam logic [3:0] GRP_RND   = 4'hC;
    localparam logic [3:0] GRP_DRAW  = 4'hD;
    localparam logic [3:0] GRP_KEY   = 4'hE;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] FN_SKP   = 8'h9E;
    localparam logic [7:0] FN_SKNP  = 8'hA1;
    localparam logic [7:0] FN_LDDT  = 8'h07;
    localparam logic [7:0] FN_WAITK = 8'h0A;
    localparam logic [7:0] FN_STDT  = 8'h15;
    localparam logic [7:0] FN_STST  = 8'h18;
    localparam logic [7:0] FN_ADDI  = 8'h1E;
    localparam logic [7:0] FN_FONT  = 8'h29;
    localparam logic [7:0] FN_BCD   = 8'h33;
    localparam logic [7:0] FN_STORE = 8'h55;
    localparam logic [7:0] FN_LOAD  = 8'h65;

    localparam logic [4:0] VF_IDX = 5'd15;

    typedef struct packed {
        logic [4:0]       step;
        logic [CNT_W-1:0] cnt;
        logic             accept;
        logic             load_out;
    } c8ic_cmd_t;

    typedef struct packed {
        logic [15:0] opcode;
    } c8ic_status_t;

    localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] addr);
        logic [MEM_AW-1:0] off;
        off = addr - FONT_BASE;
        if (addr >= FONT_BASE && off < MEM_AW'(FONT_LEN)) begin
            return FONT_ROM[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

// ===== hw/rtl/c8ic_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ic_ctrl
// Sequencer of the interpreter core: clearing pass, input and result
// handshakes, and the step order of each instruction.
// ----------------------------------------------------------------------------
module c8ic_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  c8ic_pkg::c8ic_status_t dp_status,
    output c8ic_pkg::c8ic_cmd_t    cmd
);

    logic [4:0]                 state_reg, state_next;
    logic [c8ic_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       accept, load;
    logic [3:0]                 grp, sub, x;
    logic [7:0]                 fn;

    assign grp = dp_status.opcode[15:12];
    assign x   = dp_status.opcode[11:8];
    assign sub = dp_status.opcode[3:0];
    assign fn  = dp_status.opcode[7:0];

    assign s_ready = (state_reg == c8ic_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == c8ic_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    assign cmd.step     = state_reg;
    assign cmd.cnt      = cnt_reg;
    assign cmd.accept   = accept;
    assign cmd.load_out = load;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        unique case (state_reg)
            c8ic_pkg::S_CLEAR: begin
                if (cnt_reg == c8ic_pkg::CNT_W'(c8ic_pkg::MEM_BYTES - 1)) begin
                    state_next = c8ic_pkg::S_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            c8ic_pkg::S_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    unique case (s_op)
                        c8ic_pkg::OP_WRITE:    state_next = c8ic_pkg::S_MWR;
                        c8ic_pkg::OP_EXEC:     state_next = c8ic_pkg::S_F0;
                        c8ic_pkg::OP_READ_ROW: state_next = c8ic_pkg::S_ROW0;
                        default:               state_next = c8ic_pkg::S_DONE;
                    endcase
                end
            end
            c8ic_pkg::S_MWR:  state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_ROW0: state_next = c8ic_pkg::S_ROW1;
            c8ic_pkg::S_ROW1: state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_F0:   state_next = c8ic_pkg::S_F1;
            c8ic_pkg::S_F1:   state_next = c8ic_pkg::S_F2;
            c8ic_pkg::S_F2:   state_next = c8ic_pkg::S_RX;
            c8ic_pkg::S_RX:   state_next = c8ic_pkg::S_RY;
            c8ic_pkg::S_RY:   state_next = c8ic_pkg::S_EXEC;
            c8ic_pkg::S_EXEC: begin
                cnt_next   = '0;
                state_next = c8ic_pkg::S_DONE;
                if (grp == c8ic_pkg::GRP_DRAW) begin
                    state_next = (sub == 4'h0) ? c8ic_pkg::S_VF : c8ic_pkg::S_DRAW0;
                end else if (grp == c8ic_pkg::GRP_ALU) begin
                    if (sub == c8ic_pkg::ALU_ADD || sub == c8ic_pkg::ALU_SUB ||
                        sub == c8ic_pkg::ALU_SUBN || sub == c8ic_pkg::ALU_SHR ||
                        sub == c8ic_pkg::ALU_SHL) begin
                        state_next = c8ic_pkg::S_VF;
                    end
                end else if (grp == c8ic_pkg::GRP_MISC) begin
                    if (fn == c8ic_pkg::FN_ADDI) state_next = c8ic_pkg::S_VF;
                    else if (fn == c8ic_pkg::FN_BCD) state_next = c8ic_pkg::S_BCD;
                    else if (fn == c8ic_pkg::FN_STORE) state_next = c8ic_pkg::S_ST;
                    else if (fn == c8ic_pkg::FN_LOAD) state_next = c8ic_pkg::S_LD;
                end
            end
            c8ic_pkg::S_DRAW0: state_next = c8ic_pkg::S_DRAW1;
            c8ic_pkg::S_DRAW1: begin
                if (cnt_reg[3:0] == sub - 4'd1) begin
                    state_next = c8ic_pkg::S_VF;
                    cnt_next   = '0;
                end else begin
                    state_next = c8ic_pkg::S_DRAW0;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            c8ic_pkg::S_VF: state_next = c8ic_pkg::S_DONE;
            c8ic_pkg::S_BCD: begin
                if (cnt_reg[1:0] == 2'd2) state_next = c8ic_pkg::S_DONE;
                else cnt_next = cnt_reg + 1'b1;
            end
            c8ic_pkg::S_ST: begin
                if (cnt_reg[3:0] == x) state_next = c8ic_pkg::S_DONE;
                else cnt_next = cnt_reg + 1'b1;
            end
            c8ic_pkg::S_LD: begin
                if (cnt_reg[4:0] == {1'b0, x} + 5'd1) state_next = c8ic_pkg::S_DONE;
                else cnt_next = cnt_reg + 1'b1;
            end
            c8ic_pkg::S_DONE: begin
                if (load) state_next = c8ic_pkg::S_IDLE;
            end
            default: state_next = c8ic_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= c8ic_pkg::S_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/c8ic_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ic_datapath
// Machine state of the interpreter core: main memory, frame buffer, register
// file, return stack, index, counters and the result registers.
// ----------------------------------------------------------------------------
module c8ic_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  c8ic_pkg::c8ic_cmd_t     cmd,
    output c8ic_pkg::c8ic_status_t  dp_status,
    input  logic                   cfg_valid,
    input  logic                   cfg_modern_shift_mode,
    input  logic [1:0]             s_op,
    input  logic [11:0]            s_mem_addr,
    input  logic [7:0]             s_mem_data,
    input  logic [15:0]            s_key_state,
    input  logic [7:0]             s_random_byte,
    input  logic [4:0]             s_row_select,
    output logic [63:0]            m_row_pixels,
    output logic [11:0]            m_program_counter,
    output logic [15:0]            m_executed_opcode,
    output logic [1:0]             m_status,
    output logic                   m_sound_on
);

    localparam int AW = c8ic_pkg::MEM_AW;
    localparam int SW = c8ic_pkg::SCREEN_W;

    logic [7:0]                   mem [c8ic_pkg::MEM_BYTES];
    logic [SW-1:0]                frame_mem [c8ic_pkg::SCREEN_H];
    logic [c8ic_pkg::SCREEN_H-1:0] fvalid_reg;
    logic [7:0]                   rf_reg [16];
    logic [AW-1:0]                stack_mem [c8ic_pkg::STACK_DEPTH];

    logic [AW-1:0]                pc_reg, pc_next;
    logic [15:0]                  idx_reg, idx_next;
    logic [c8ic_pkg::LVL_W-1:0]   level_reg, level_next;
    logic [7:0]                   delay_reg, delay_next;
    logic [7:0]                   sound_reg, sound_next;
    logic                         shift_mode_reg;
    logic [15:0]                  opcode_reg, opcode_next;
    logic [1:0]                   status_reg, status_next;
    logic [7:0]                   vx_reg, vy_reg, hi_reg, mem_rd_reg;
    logic                         flag_reg, flag_next, vf_we_reg, vf_we_next;
    logic [SW-1:0]                frame_rd_reg, row_res_reg;
    logic                         fvalid_rd_reg;
    logic [1:0]                   in_op_reg;
    logic [AW-1:0]                in_addr_reg;
    logic [7:0]                   in_data_reg, in_rnd_reg;
    logic [15:0]                  in_key_reg;
    logic [4:0]                   in_row_reg;

    logic                         mem_we, rf_we, fclear, fwe, push;
    logic [AW-1:0]                mem_wa, mem_ra, pop_addr;
    logic [7:0]                   mem_wd, rf_wd, rf_rd;
    logic [3:0]                   rf_wa, rf_ra;
    logic [c8ic_pkg::ROW_AW-1:0]  frame_ra, draw_row;
    logic [SW-1:0]                row_word, sprite, mask, frame_wd;
    logic [3:0]                   grp, x, y, sub, key_idx;
    logic [7:0]                   nn, fn, sum8;
    logic [AW-1:0]                nnn, idx_off;
    logic [8:0]                   add9;
    logic [15:0]                  sum16;
    logic [7:0]                   src;
    logic                         key_any;
    logic [1:0]                   hund;
    logic [6:0]                   rem;
    logic [14:0]                  tens_prod;
    logic [3:0]                   tens, units;
    logic [7:0]                   digit;

    assign grp = opcode_reg[15:12];
    assign x   = opcode_reg[11:8];
    assign y   = opcode_reg[7:4];
    assign sub = opcode_reg[3:0];
    assign nn  = opcode_reg[7:0];
    assign fn  = opcode_reg[7:0];
    assign nnn = opcode_reg[11:0];

    assign dp_status.opcode = opcode_reg;

    assign rf_rd    = rf_reg[rf_ra];
    assign idx_off  = idx_reg[AW-1:0] + cmd.cnt;
    assign draw_row = vy_reg[c8ic_pkg::ROW_AW-1:0] + cmd.cnt[c8ic_pkg::ROW_AW-1:0];
    assign row_word = fvalid_rd_reg ? frame_rd_reg : '0;
    assign sprite   = {mem_rd_reg, {(SW - 8){1'b0}}};
    assign mask     = (sprite >> vx_reg[c8ic_pkg::COL_AW-1:0]) |
                      (sprite << (7'(SW) - {1'b0, vx_reg[c8ic_pkg::COL_AW-1:0]}));
    assign frame_wd = row_word ^ mask;
    assign pop_addr = stack_mem[c8ic_pkg::STK_AW'(level_reg - 1'b1)];
    assign add9     = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign sum8     = vx_reg + nn;
    assign sum16    = idx_reg + {8'h00, vx_reg};
    assign src      = shift_mode_reg ? vx_reg : vy_reg;

    // BCD digits of VX
    assign hund      = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem       = 7'(vx_reg - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0)));
    assign tens_prod = 15'(rem) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign units     = 4'(rem - 7'(tens) * 7'd10);

    always_comb begin
        key_idx = 4'd0;
        key_any = 1'b0;
        for (int i = 15; i >= 0; i--) begin
            if (in_key_reg[i]) begin
                key_idx = 4'(i);
                key_any = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (cmd.cnt[1:0])
            2'd0:    digit = {6'd0, hund};
            2'd1:    digit = {4'd0, tens};
            default: digit = {4'd0, units};
        endcase
    end

    always_comb begin
        pc_next     = pc_reg;
        idx_next    = idx_reg;
        level_next  = level_reg;
        delay_next  = delay_reg;
        sound_next  = sound_reg;
        opcode_next = opcode_reg;
        status_next = status_reg;
        flag_next   = flag_reg;
        vf_we_next  = vf_we_reg;
        mem_we      = 1'b0;
        mem_wa      = in_addr_reg;
        mem_wd      = in_data_reg;
        mem_ra      = pc_reg;
        rf_we       = 1'b0;
        rf_wa       = x;
        rf_wd       = 8'h00;
        rf_ra       = x;
        frame_ra    = draw_row;
        fclear      = 1'b0;
        fwe         = 1'b0;
        push        = 1'b0;
        unique case (cmd.step)
            c8ic_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = cmd.cnt;
                mem_wd = c8ic_pkg::font_byte(cmd.cnt);
            end
            c8ic_pkg::S_MWR:  mem_we = 1'b1;
            c8ic_pkg::S_ROW0: frame_ra = in_row_reg;
            c8ic_pkg::S_F0:   mem_ra = pc_reg;
            c8ic_pkg::S_F1:   mem_ra = pc_reg + 1'b1;
            c8ic_pkg::S_F2: begin
                opcode_next = {hi_reg, mem_rd_reg};
                pc_next     = pc_reg + AW'(2);
            end
            c8ic_pkg::S_RX: rf_ra = x;
            c8ic_pkg::S_RY: rf_ra = (grp == c8ic_pkg::GRP_JPV0) ? 4'd0 : y;
            c8ic_pkg::S_EXEC: begin
                vf_we_next = 1'b0;
                unique case (grp)
                    c8ic_pkg::GRP_SYS: begin
                        if (opcode_reg == c8ic_pkg::OPC_CLS) begin
                            fclear = 1'b1;
                        end else if (opcode_reg == c8ic_pkg::OPC_RET) begin
                            if (level_reg == '0) begin
                                status_next = c8ic_pkg::ST_UNDERFLOW;
                            end else begin
                                level_next = level_reg - 1'b1;
                                pc_next    = pop_addr;
                            end
                        end
                    end
                    c8ic_pkg::GRP_JP: pc_next = nnn;
                    c8ic_pkg::GRP_CALL: begin
                        if (level_reg >= c8ic_pkg::LVL_W'(c8ic_pkg::STACK_DEPTH)) begin
                            status_next = c8ic_pkg::ST_OVERFLOW;
                        end else begin
                            push       = 1'b1;
                            level_next = level_reg + 1'b1;
                            pc_next    = nnn;
                        end
                    end
                    c8ic_pkg::GRP_SE:    if (vx_reg == nn) pc_next = pc_reg + AW'(2);
                    c8ic_pkg::GRP_SNE:   if (vx_reg != nn) pc_next = pc_reg + AW'(2);
                    c8ic_pkg::GRP_SEXY:  if (vx_reg == vy_reg) pc_next = pc_reg + AW'(2);
                    c8ic_pkg::GRP_SNEXY: if (vx_reg != vy_reg) pc_next = pc_reg + AW'(2);
                    c8ic_pkg::GRP_LD: begin
                        rf_we = 1'b1;
                        rf_wd = nn;
                    end
                    c8ic_pkg::GRP_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = sum8;
                    end
                    c8ic_pkg::GRP_ALU: begin
                        unique case (sub)
                            c8ic_pkg::ALU_MOV: begin
                                rf_we = 1'b1;
                                rf_wd = vy_reg;
                            end
                            c8ic_pkg::ALU_OR: begin
                                rf_we = 1'b1;
                                rf_wd = vx_reg | vy_reg;
                            end
                            c8ic_pkg::ALU_AND: begin
                                rf_we = 1'b1;
                                rf_wd = vx_reg & vy_reg;
                            end
                            c8ic_pkg::ALU_XOR: begin
                                rf_we = 1'b1;
                                rf_wd = vx_reg ^ vy_reg;
                            end
                            c8ic_pkg::ALU_ADD: begin
                                rf_we      = 1'b1;
                                rf_wd      = add9[7:0];
                                vf_we_next = 1'b1;
                                flag_next  = add9[8];
                            end
                            c8ic_pkg::ALU_SUB: begin
                                rf_we      = 1'b1;
                                rf_wd      = vx_reg - vy_reg;
                                vf_we_next = 1'b1;
                                flag_next  = (vx_reg >= vy_reg);
                            end
                            c8ic_pkg::ALU_SUBN: begin
                                rf_we      = 1'b1;
                                rf_wd      = vy_reg - vx_reg;
                                vf_we_next = 1'b1;
                                flag_next  = (vy_reg >= vx_reg);
                            end
                            c8ic_pkg::ALU_SHR: begin
                                rf_we      = 1'b1;
                                rf_wd      = {1'b0, src[7:1]};
                                vf_we_next = 1'b1;
                                flag_next  = src[0];
                            end
                            c8ic_pkg::ALU_SHL: begin
                                rf_we      = 1'b1;
                                rf_wd      = {src[6:0], 1'b0};
                                vf_we_next = 1'b1;
                                flag_next  = src[7];
                            end
                            default: ;
                        endcase
                    end
                    c8ic_pkg::GRP_LDI:  idx_next = {4'h0, nnn};
                    c8ic_pkg::GRP_JPV0: pc_next = nnn + {4'h0, vy_reg};
                    c8ic_pkg::GRP_RND: begin
                        rf_we = 1'b1;
                        rf_wd = in_rnd_reg & nn;
                    end
                    c8ic_pkg::GRP_DRAW: begin
                        vf_we_next = 1'b1;
                        flag_next  = 1'b0;
                    end
                    c8ic_pkg::GRP_KEY: begin
                        if (fn == c8ic_pkg::FN_SKP && in_key_reg[vx_reg[3:0]]) begin
                            pc_next = pc_reg + AW'(2);
                        end else if (fn == c8ic_pkg::FN_SKNP && !in_key_reg[vx_reg[3:0]]) begin
                            pc_next = pc_reg + AW'(2);
                        end
                    end
                    default: begin
                        unique case (fn)
                            c8ic_pkg::FN_LDDT: begin
                                rf_we = 1'b1;
                                rf_wd = delay_reg;
                            end
                            c8ic_pkg::FN_STDT: delay_next = vx_reg;
                            c8ic_pkg::FN_STST: sound_next = vx_reg;
                            c8ic_pkg::FN_ADDI: begin
                                idx_next   = sum16;
                                vf_we_next = (sum16 > 16'h0FFF);
                                flag_next  = 1'b1;
                            end
                            c8ic_pkg::FN_WAITK: begin
                                if (key_any) begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'h0, key_idx};
                                end else begin
                                    pc_next     = pc_reg - AW'(2);
                                    status_next = c8ic_pkg::ST_KEY_WAIT;
                                end
                            end
                            c8ic_pkg::FN_FONT: begin
                                idx_next = {4'h0, c8ic_pkg::FONT_BASE} +
                                           16'(vx_reg[3:0]) * 16'd5;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            c8ic_pkg::S_VF: begin
                rf_we = vf_we_reg;
                rf_wa = 4'(c8ic_pkg::VF_IDX);
                rf_wd = {7'd0, flag_reg};
            end
            c8ic_pkg::S_DRAW0: begin
                mem_ra   = idx_off;
                frame_ra = draw_row;
            end
            c8ic_pkg::S_DRAW1: begin
                fwe       = 1'b1;
                flag_next = flag_reg | (|(row_word & mask));
            end
            c8ic_pkg::S_BCD: begin
                mem_we = 1'b1;
                mem_wa = idx_off;
                mem_wd = digit;
            end
            c8ic_pkg::S_ST: begin
                rf_ra  = cmd.cnt[3:0];
                mem_we = 1'b1;
                mem_wa = idx_off;
                mem_wd = rf_rd;
            end
            c8ic_pkg::S_LD: begin
                mem_ra = idx_off;
                if (cmd.cnt != '0) begin
                    rf_we = 1'b1;
                    rf_wa = 4'(cmd.cnt - 1'b1);
                    rf_wd = mem_rd_reg;
                end
            end
            default: ;
        endcase
        if (cmd.accept) begin
            opcode_next = '0;
            status_next = c8ic_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (fwe) begin
            frame_mem[draw_row] <= frame_wd;
        end
        frame_rd_reg  <= frame_mem[frame_ra];
        fvalid_rd_reg <= fvalid_reg[frame_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= c8ic_pkg::PC_RESET;
            idx_reg        <= '0;
            level_reg      <= '0;
            delay_reg      <= '0;
            sound_reg      <= '0;
            shift_mode_reg <= 1'b0;
            opcode_reg     <= '0;
            status_reg     <= c8ic_pkg::ST_OK;
            fvalid_reg     <= '0;
            for (int i = 0; i < 16; i++) begin
                rf_reg[i] <= 8'h00;
            end
        end else begin
            pc_reg     <= pc_next;
            idx_reg    <= idx_next;
            level_reg  <= level_next;
            delay_reg  <= delay_next;
            sound_reg  <= sound_next;
            opcode_reg <= opcode_next;
            status_reg <= status_next;
            if (cfg_valid) begin
                shift_mode_reg <= cfg_modern_shift_mode;
            end
            if (rf_we) begin
                rf_reg[rf_wa] <= rf_wd;
            end
            if (fclear) begin
                fvalid_reg <= '0;
            end else if (fwe) begin
                fvalid_reg[draw_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        flag_reg  <= flag_next;
        vf_we_reg <= vf_we_next;
        if (push) begin
            stack_mem[level_reg[c8ic_pkg::STK_AW-1:0]] <= pc_reg;
        end
        if (cmd.step == c8ic_pkg::S_F1) begin
            hi_reg <= mem_rd_reg;
        end
        if (cmd.step == c8ic_pkg::S_RX) begin
            vx_reg <= rf_rd;
        end
        if (cmd.step == c8ic_pkg::S_RY) begin
            vy_reg <= rf_rd;
        end
        if (cmd.accept) begin
            in_op_reg   <= s_op;
            in_addr_reg <= s_mem_addr;
            in_data_reg <= s_mem_data;
            in_key_reg  <= s_key_state;
            in_rnd_reg  <= s_random_byte;
            in_row_reg  <= s_row_select;
            row_res_reg <= '0;
        end else if (cmd.step == c8ic_pkg::S_ROW1) begin
            row_res_reg <= row_word;
        end
        if (cmd.load_out) begin
            m_row_pixels      <= (in_op_reg == c8ic_pkg::OP_READ_ROW) ? row_res_reg : '0;
            m_program_counter <= pc_reg;
            m_executed_opcode <= opcode_reg;
            m_status          <= status_reg;
            m_sound_on        <= (sound_reg != 8'h00);
        end
    end

endmodule

// ===== hw/rtl/chip8_interpreter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// CHIP-8 virtual machine: memory byte writes, one-instruction steps and
// display row reads over valid/ready channels, one result per transaction.
// ----------------------------------------------------------------------------
// After reset the core sweeps its 4096-byte memory, one byte a cycle, to load
// zeros and the hex font at 0x50; it takes no transaction during this sweep.
// Items are then handled one at a time by a sequencer over one register-file
// read port and a memory and frame buffer with one write and one read port
// each. A memory write has a write step, a row read a read and a capture
// step, an instruction fetch steps, two register reads and execute, each then
// a result step; flag setters add a flag write, DXYN a read and a write step
// per sprite row, BCD a step per digit; block store and load step through the
// registers. The result register lets the next transaction be accepted while
// a finished result waits. The configuration write is always ready.
module chip8_interpreter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [11:0] s_mem_addr,
    input  logic [7:0]  s_mem_data,
    input  logic [15:0] s_key_state,
    input  logic [7:0]  s_random_byte,
    input  logic [4:0]  s_row_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_row_pixels,
    output logic [11:0] m_program_counter,
    output logic [15:0] m_executed_opcode,
    output logic [1:0]  m_status,
    output logic        m_sound_on,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_modern_shift_mode
);

    c8ic_pkg::c8ic_cmd_t    cmd;
    c8ic_pkg::c8ic_status_t dp_status;

    assign cfg_ready = 1'b1;

    c8ic_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    c8ic_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .dp_status             (dp_status),
        .cfg_valid             (cfg_valid),
        .cfg_modern_shift_mode (cfg_modern_shift_mode),
        .s_op                  (s_op),
        .s_mem_addr            (s_mem_addr),
        .s_mem_data            (s_mem_data),
        .s_key_state           (s_key_state),
        .s_random_byte         (s_random_byte),
        .s_row_select          (s_row_select),
        .m_row_pixels          (m_row_pixels),
        .m_program_counter     (m_program_counter),
        .m_executed_opcode     (m_executed_opcode),
        .m_status              (m_status),
        .m_sound_on            (m_sound_on)
    );

endmodule

// ===== hw/rtl/c8ic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ic_checker
// Port-level checks of the interpreter core, bound to the top level.
// ----------------------------------------------------------------------------
module c8ic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_row_pixels,
    input logic [15:0] m_executed_opcode,
    input logic [1:0]  m_status
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_pixels) && $stable(m_status))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_row_only_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_pixels != 64'd0 |-> m_executed_opcode == 16'd0 &&
        m_status == c8ic_pkg::ST_OK)
        else $error("row pixels on a non-read transaction");

    a_status_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != c8ic_pkg::ST_OK |-> m_row_pixels == 64'd0)
        else $error("status set on a non-execute transaction");

endmodule

bind chip8_interpreter_core c8ic_checker u_c8ic_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_row_pixels      (m_row_pixels),
    .m_executed_opcode (m_executed_opcode),
    .m_status          (m_status)
);

// ===== bench/chip8_interpreter_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core_test
// Drives memory writes, instruction steps and row reads into the interpreter
// core with random idling on both channels. A behavioral copy of the machine
// predicts every result, and a scoreboard compares the results field by field.
// ----------------------------------------------------------------------------
import c8ic_pkg::*;

typedef struct {
    logic [63:0] row;
    logic [11:0] pc;
    logic [15:0] opc;
    logic [1:0]  status;
    logic        sound;
} step_result_t;

class step_scoreboard;
    step_result_t pending[$];
    int           errors;

    function void note_item(step_result_t r);
        pending = {pending, r};
    endfunction

    function void check_result(step_result_t got);
        step_result_t want;
        if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.row !== want.row) begin
            $error("row_pixels expected %h actual %h", want.row, got.row);
            errors++;
        end
        if (got.pc !== want.pc) begin
            $error("program_counter expected %h actual %h", want.pc, got.pc);
            errors++;
        end
        if (got.opc !== want.opc) begin
            $error("executed_opcode expected %h actual %h", want.opc, got.opc);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.sound !== want.sound) begin
            $error("sound_on expected %0d actual %0d", want.sound, got.sound);
            errors++;
        end
    endfunction
endclass

module chip8_interpreter_core_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_NOP;
    logic [11:0] s_mem_addr = '0;
    logic [7:0]  s_mem_data = '0;
    logic [15:0] s_key_state = '0;
    logic [7:0]  s_random_byte = '0;
    logic [4:0]  s_row_select = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_row_pixels;
    logic [11:0] m_program_counter;
    logic [15:0] m_executed_opcode;
    logic [1:0]  m_status;
    logic        m_sound_on;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_modern_shift_mode = 1'b0;

    chip8_interpreter_core uut (.*);

    always #5 aclk = ~aclk;

    // machine copy
    logic [7:0]  mem [MEM_BYTES];
    logic [63:0] fb [SCREEN_H];
    logic [11:0] pc;
    logic [15:0] ireg;
    logic [7:0]  v [16];
    logic [11:0] stk [STACK_DEPTH];
    int          level;
    logic [7:0]  dly, snd;
    logic        modern;

    step_scoreboard sb = new();
    int send_idle, recv_idle;
    int items_sent;

    task automatic machine_reset();
        foreach (mem[i]) mem[i] = (i >= FONT_BASE && i < FONT_BASE + FONT_LEN) ?
            FONT_ROM[i - FONT_BASE] : 8'h00;
        foreach (fb[i]) fb[i] = '0;
        foreach (v[i]) v[i] = '0;
        foreach (stk[i]) stk[i] = '0;
        pc = PC_RESET; ireg = '0; level = 0; dly = '0; snd = '0; modern = 1'b0;
    endtask

    function automatic logic [1:0] run_instr(logic [15:0] w, logic [15:0] keys,
                                             logic [7:0] rnd);
        logic [3:0] x, y, n;
        logic [7:0] nn, vx, vy, src, bits;
        logic [8:0] sum;
        logic [5:0] px;
        logic [4:0] py;
        logic [63:0] m;
        int k;
        x = w[11:8]; y = w[7:4]; n = w[3:0]; nn = w[7:0];
        vx = v[x]; vy = v[y];
        case (w[15:12])
            GRP_SYS: begin
                if (w == OPC_CLS) begin
                    foreach (fb[i]) fb[i] = '0;
                end else if (w == OPC_RET) begin
                    if (level == 0) return ST_UNDERFLOW;
                    level--;
                    pc = stk[level];
                end
            end
            GRP_JP: pc = w[11:0];
            GRP_CALL: begin
                if (level >= STACK_DEPTH) return ST_OVERFLOW;
                stk[level] = pc;
                level++;
                pc = w[11:0];
            end
            GRP_SE:    if (vx == nn) pc += 12'd2;
            GRP_SNE:   if (vx != nn) pc += 12'd2;
            GRP_SEXY:  if (vx == vy) pc += 12'd2;
            GRP_LD:    v[x] = nn;
            GRP_ADD:   v[x] = vx + nn;
            GRP_SNEXY: if (vx != vy) pc += 12'd2;
            GRP_LDI:   ireg = {4'h0, w[11:0]};
            GRP_JPV0:  pc = w[11:0] + {4'h0, v[0]};
            GRP_RND:   v[x] = rnd & nn;
            GRP_ALU: begin
                case (n)
                    ALU_MOV: v[x] = vy;
                    ALU_OR:  v[x] = vx | vy;
                    ALU_AND: v[x] = vx & vy;
                    ALU_XOR: v[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = vx + vy; v[x] = sum[7:0]; v[15] = {7'd0, sum[8]};
                    end
                    ALU_SUB:  begin v[x] = vx - vy; v[15] = {7'd0, vx >= vy}; end
                    ALU_SUBN: begin v[x] = vy - vx; v[15] = {7'd0, vy >= vx}; end
                    ALU_SHR: begin
                        src = modern ? vx : vy; v[x] = src >> 1; v[15] = {7'd0, src[0]};
                    end
                    ALU_SHL: begin
                        src = modern ? vx : vy; v[x] = src << 1; v[15] = {7'd0, src[7]};
                    end
                    default: ;
                endcase
            end
            GRP_DRAW: begin
                v[15] = 8'd0;
                for (int r = 0; r < n; r++) begin
                    bits = mem[12'(ireg + r)];
                    py = 5'(vy + r);
                    for (int c = 0; c < 8; c++) begin
                        if (bits[7-c]) begin
                            px = 6'(vx + c);
                            m = 64'd1 << (63 - px);
                            if (fb[py] & m) v[15] = 8'd1;
                            fb[py] ^= m;
                        end
                    end
                end
            end
            GRP_KEY: begin
                if (nn == FN_SKP && keys[vx[3:0]]) pc += 12'd2;
                else if (nn == FN_SKNP && !keys[vx[3:0]]) pc += 12'd2;
            end
            GRP_MISC: begin
                case (nn)
                    FN_LDDT: v[x] = dly;
                    FN_STDT: dly = vx;
                    FN_STST: snd = vx;
                    FN_ADDI: begin
                        ireg = ireg + vx;
                        if (ireg > 16'h0FFF) v[15] = 8'd1;
                    end
                    FN_WAITK: begin
                        for (k = 0; k < 16; k++) if (keys[k]) break;
                        if (k == 16) begin
                            pc -= 12'd2;
                            return ST_KEY_WAIT;
                        end
                        v[x] = k[7:0];
                    end
                    FN_FONT: ireg = 16'(FONT_BASE) + 16'(vx[3:0]) * 16'd5;
                    FN_BCD: begin
                        mem[12'(ireg)] = vx / 8'd100;
                        mem[12'(ireg + 1)] = (vx / 8'd10) % 8'd10;
                        mem[12'(ireg + 2)] = vx % 8'd10;
                    end
                    FN_STORE: for (int i = 0; i <= x; i++) mem[12'(ireg + i)] = v[i];
                    FN_LOAD:  for (int i = 0; i <= x; i++) v[i] = mem[12'(ireg + i)];
                    default: ;
                endcase
            end
        endcase
        return ST_OK;
    endfunction

    function automatic step_result_t predict_step(logic [1:0] op, logic [11:0] a,
        logic [7:0] d, logic [15:0] keys, logic [7:0] rnd, logic [4:0] rs);
        step_result_t r;
        logic [15:0] w;
        r.row = '0; r.opc = '0; r.status = ST_OK;
        if (op == OP_WRITE) begin
            mem[a] = d;
        end else if (op == OP_EXEC) begin
            w = {mem[pc], mem[12'(pc + 1)]};
            pc += 12'd2;
            r.opc = w;
            r.status = run_instr(w, keys, rnd);
        end else if (op == OP_READ_ROW) begin
            r.row = fb[rs];
        end
        r.pc = pc;
        r.sound = snd != 0;
        return r;
    endfunction

    task automatic send_item(logic [1:0] op, logic [11:0] a, logic [7:0] d,
                             logic [15:0] keys, logic [7:0] rnd, logic [4:0] rs);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid <= 1'b1; s_op <= op; s_mem_addr <= a; s_mem_data <= d;
        s_key_state <= keys; s_random_byte <= rnd; s_row_select <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(predict_step(op, a, d, keys, rnd, rs));
        items_sent++;
    endtask

    task automatic poke(logic [11:0] a, logic [7:0] d);
        send_item(OP_WRITE, a, d, 16'($urandom), 8'($urandom), 5'($urandom));
    endtask

    task automatic exec(logic [15:0] keys = 16'h0000);
        send_item(OP_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom),
                  5'($urandom));
    endtask

    // place one instruction at the predicted pc and run it
    task automatic run_word(logic [15:0] w, logic [15:0] keys = 16'h0000);
        logic [11:0] at;
        at = pc;
        poke(at, w[15:8]);
        poke(12'(at + 1), w[7:0]);
        exec(keys);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_mode(logic val);
        cfg_valid <= 1'b1;
        cfg_modern_shift_mode <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        modern = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word(output logic [15:0] w);
        logic [3:0] g;
        g = 4'($urandom_range(15));
        w = {g, 12'($urandom)};
        case ($urandom_range(9))
            0: w = OPC_RET;
            1: w = OPC_CLS;
            2: w = {GRP_MISC, 4'($urandom), FN_STORE};
            3: w = {GRP_MISC, 4'($urandom), FN_LOAD};
            4: w = {GRP_MISC, 4'($urandom), FN_BCD};
            5: w = {GRP_ALU, 8'($urandom), 4'($urandom_range(7))};
            6: w = {GRP_DRAW, 8'($urandom), 4'($urandom_range(6))};
            default: ;
        endcase
        // turn some calls into returns while the return stack is not empty
        if (g == GRP_CALL && level > 0 && $urandom_range(1)) w = OPC_RET;
    endtask

    task automatic random_phase(int count);
        logic [15:0] w;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                random_word(w);
                run_word(w, $urandom_range(3) == 0 ? 16'h0000 : 16'($urandom));
                i += 2;
            end else if (sel < 80) begin
                send_item(OP_READ_ROW, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
            end else if (sel < 88) begin
                poke(12'($urandom), 8'($urandom));
            end else if (sel < 96) begin
                exec(16'($urandom));
            end else begin
                send_item(OP_NOP, 12'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom), 5'($urandom));
            end
        end
    endtask

    always @(posedge aclk) begin
        step_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.row = m_row_pixels; got.pc = m_program_counter;
            got.opc = m_executed_opcode; got.status = m_status;
            got.sound = m_sound_on;
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        m_ready <= (recv_idle == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        machine_reset();
        send_idle = 34; recv_idle = 52; items_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        write_mode(1'b0);
        poke(12'hFFF, 8'hFF);
        poke(12'h000, 8'h00);
        run_word(16'h6A81);
        run_word(16'h6BFF);
        run_word(16'h8AB6);
        run_word(16'h8ABE);
        run_word(16'h6F90);
        run_word(16'h8FF4);
        run_word(16'h8FA5);
        run_word(16'h8FB7);
        run_word(16'h00EE);
        run_word(16'hFA0A, 16'h0000);
        exec(16'h8000);
        run_word(16'hAFFE);
        run_word(16'hD0B5);
        run_word(16'hD0B5);
        send_item(OP_READ_ROW, 12'd0, 8'd0, 16'd0, 8'd0, 5'd31);
        run_word(16'hFB1E);
        run_word(16'hFB33);
        run_word(16'hF829);
        run_word(16'hFF55);
        run_word(16'hFF65);
        run_word(16'hC0F0);
        run_word(16'hE19E, 16'hFFFF);
        run_word(16'hE1A1, 16'h0000);
        run_word(16'hFB18);
        run_word(16'hFB15);
        run_word(16'hF207);
        drain_results();

        write_mode(1'b1);
        for (int i = 0; i < 17; i++) run_word({GRP_CALL, 12'(pc + 2 + $urandom_range(8) * 2)});
        run_word(16'h8AB6);
        run_word(16'h8ABE);
        for (int i = 0; i < 17; i++) run_word(OPC_RET);
        run_word(16'h6000);
        run_word(16'hBFFE);
        run_word(16'h00E0);
        drain_results();

        random_phase(585);
        drain_results();
        write_mode(1'b0);
        send_idle = 52; recv_idle = 34;
        random_phase(585);
        drain_results();
        write_mode(1'b1);
        send_idle = 0; recv_idle = 0;
        random_phase(585);
        drain_results();

        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
